// ===== hw/rtl/uer_pkg.sv =====
// Package for the ultrasonic echo ranger: phase codes, constants, register map and shared types.
package uer_pkg;

   // Measurement phases
   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_TRIG = 2'd1,
      PH_WAIT = 2'd2,
      PH_MEAS = 2'd3
   } phase_type;

   // Register indexes on the configuration port (word address)
   localparam logic [2:0] REG_TRIG_WIDTH   = 3'd0;
   localparam logic [2:0] REG_RISE_TIMEOUT = 3'd1;
   localparam logic [2:0] REG_ECHO_TIMEOUT = 3'd2;
   localparam logic [2:0] REG_MIN_DIST     = 3'd3;
   localparam logic [2:0] REG_MAX_DIST     = 3'd4;
   localparam logic [2:0] REG_ALARM_DIST   = 3'd5;

   // Field widths
   localparam int TRIG_W  = 8;
   localparam int TIME_W  = 16;
   localparam int DIST_W  = 11;

   // Register reset values
   localparam logic [TRIG_W-1:0] TRIG_WIDTH_RST   = 8'd15;
   localparam logic [TIME_W-1:0] RISE_TIMEOUT_RST = 16'd1000;
   localparam logic [TIME_W-1:0] ECHO_TIMEOUT_RST = 16'd30000;
   localparam logic [DIST_W-1:0] MIN_DIST_RST     = 11'd2;
   localparam logic [DIST_W-1:0] MAX_DIST_RST     = 11'd400;
   localparam logic [DIST_W-1:0] ALARM_DIST_RST   = 11'd3;

   // Measurement constants
   localparam logic [TIME_W-1:0] MIN_ECHO_TICKS = 16'd150;
   localparam logic [DIST_W-1:0] INVALID_CM     = 11'd999;

   // t / 58 == (t * 72316) >> 22 for every 16-bit t
   localparam int           RECIP_SHIFT = 22;
   localparam logic [16:0]  RECIP_58    = 17'd72316;

   // Finished measurement handed from the sequencer stage to the range check
   typedef struct packed {
      logic              pre_ok;     // not forced invalid, echo time within limits
      logic [TIME_W-1:0] high_ticks;
   } finish_type;

   // Range check outcome
   typedef struct packed {
      logic              valid;
      logic [DIST_W-1:0] distance;
      logic              too_close;
   } range_type;

endpackage

// ===== hw/rtl/uer_range_check.sv =====
// Echo time to centimetres conversion and distance limit checks.
module uer_range_check (
   input  uer_pkg::finish_type        fin,
   input  logic [uer_pkg::DIST_W-1:0] min_dist,
   input  logic [uer_pkg::DIST_W-1:0] max_dist,
   input  logic [uer_pkg::DIST_W-1:0] alarm_dist,
   output uer_pkg::range_type         result
);

   logic [uer_pkg::TIME_W+16:0] product;
   logic [uer_pkg::DIST_W-1:0]  cm_value;
   logic                        ok;

   // Divide by 58 through the reciprocal
   assign product  = {17'd0, fin.high_ticks} * {16'd0, uer_pkg::RECIP_58};
   assign cm_value = product[uer_pkg::RECIP_SHIFT +: uer_pkg::DIST_W];

   assign ok = fin.pre_ok && (cm_value <= max_dist) && (cm_value >= min_dist);

   always_comb begin
      if (ok) begin
         result.valid     = 1'b1;
         result.distance  = cm_value;
         result.too_close = (cm_value <= alarm_dist);
      end else begin
         result.valid     = 1'b0;
         result.distance  = uer_pkg::INVALID_CM;
         result.too_close = 1'b0;
      end
   end

endmodule

// ===== hw/rtl/ultrasonic_echo_ranger.sv =====
// Top level of the ultrasonic echo ranger: phase sequencer, range stage and ports.
//
//  channel   dir  handshake              contents
//  req_*     in   tvalid/tready          tuser = start, tdata[0] = echo level
//  rsp_*     out  tvalid/tready          tdata = trigger, busy, done, valid, distance, too close
//  csr_*     in   psel/penable/pready    six limit and timing registers, 32-bit data
//
//  One request per cycle unless the result side stalls; each result passes both stage registers.
//  Stage one updates phase and tick counter, stage two divides by 58 with one multiplier
//  and checks the distance limits into the result register.
//  Both stages advance together whenever the result register is empty or being taken.
//  Reset is synchronous; it resets configuration, sequencer, valid and last-result registers.
module ultrasonic_echo_ranger #(
   parameter int COUNT_WIDTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [0] echo_level, [7:1] zero
   input  logic        req_tuser,   // [0] req_type (1 = start, 0 = tick)
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [0] trig_level, [1] busy_res, [2] done_res,
                                    // [3] valid_res, [14:4] distance_cm, [15] too_close
   // configuration port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int CMP_W = (COUNT_WIDTH > uer_pkg::TIME_W) ? COUNT_WIDTH : uer_pkg::TIME_W;
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

   // Configuration registers
   logic [uer_pkg::TRIG_W-1:0] trig_width_ff;
   logic [uer_pkg::TIME_W-1:0] rise_timeout_ff;
   logic [uer_pkg::TIME_W-1:0] echo_timeout_ff;
   logic [uer_pkg::DIST_W-1:0] min_dist_ff;
   logic [uer_pkg::DIST_W-1:0] max_dist_ff;
   logic [uer_pkg::DIST_W-1:0] alarm_dist_ff;
   logic                       csr_write;
   logic [2:0]                 csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         trig_width_ff   <= uer_pkg::TRIG_WIDTH_RST;
         rise_timeout_ff <= uer_pkg::RISE_TIMEOUT_RST;
         echo_timeout_ff <= uer_pkg::ECHO_TIMEOUT_RST;
         min_dist_ff     <= uer_pkg::MIN_DIST_RST;
         max_dist_ff     <= uer_pkg::MAX_DIST_RST;
         alarm_dist_ff   <= uer_pkg::ALARM_DIST_RST;
      end else if (csr_write) begin
         unique case (csr_index)
            uer_pkg::REG_TRIG_WIDTH:   trig_width_ff   <= csr_pwdata[uer_pkg::TRIG_W-1:0];
            uer_pkg::REG_RISE_TIMEOUT: rise_timeout_ff <= csr_pwdata[uer_pkg::TIME_W-1:0];
            uer_pkg::REG_ECHO_TIMEOUT: echo_timeout_ff <= csr_pwdata[uer_pkg::TIME_W-1:0];
            uer_pkg::REG_MIN_DIST:     min_dist_ff     <= csr_pwdata[uer_pkg::DIST_W-1:0];
            uer_pkg::REG_MAX_DIST:     max_dist_ff     <= csr_pwdata[uer_pkg::DIST_W-1:0];
            uer_pkg::REG_ALARM_DIST:   alarm_dist_ff   <= csr_pwdata[uer_pkg::DIST_W-1:0];
            default: ;
         endcase
      end
   end

   // Register readback
   always_comb begin
      unique case (csr_index)
         uer_pkg::REG_TRIG_WIDTH:   csr_prdata = {24'd0, trig_width_ff};
         uer_pkg::REG_RISE_TIMEOUT: csr_prdata = {16'd0, rise_timeout_ff};
         uer_pkg::REG_ECHO_TIMEOUT: csr_prdata = {16'd0, echo_timeout_ff};
         uer_pkg::REG_MIN_DIST:     csr_prdata = {21'd0, min_dist_ff};
         uer_pkg::REG_MAX_DIST:     csr_prdata = {21'd0, max_dist_ff};
         uer_pkg::REG_ALARM_DIST:   csr_prdata = {21'd0, alarm_dist_ff};
         default:                   csr_prdata = 32'd0;
      endcase
   end

   // Pipeline advance: whole pipe moves when the result register can take data
   logic advance;
   logic req_accept;

   assign advance    = !rsp_tvalid || rsp_tready;
   assign req_tready = advance;
   assign req_accept = req_tvalid && req_tready;

   // Stage one: phase sequencer
   uer_pkg::phase_type       phase_ff, phase_in;
   logic [COUNT_WIDTH-1:0]   tick_count_ff, tick_count_in;
   logic [COUNT_WIDTH-1:0]   count_inc;
   logic [CMP_W-1:0]         count_inc_ext;
   logic [CMP_W-1:0]         count_ext;
   logic                     count_sat;
   logic                     start;
   logic                     echo;
   logic                     done_in;
   logic                     forced_in;

   assign start         = req_tuser;
   assign echo          = req_tdata[0];
   assign count_inc     = (tick_count_ff == COUNT_MAX) ? tick_count_ff
                                                       : tick_count_ff + COUNT_WIDTH'(1);
   assign count_sat     = (count_inc == COUNT_MAX);
   assign count_inc_ext = CMP_W'(count_inc);
   assign count_ext     = CMP_W'(tick_count_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= uer_pkg::PH_IDLE;
         tick_count_ff <= '0;
      end else if (req_accept) begin
         phase_ff      <= phase_in;
         tick_count_ff <= tick_count_in;
      end
   end

   always_comb begin
      phase_in      = phase_ff;
      tick_count_in = tick_count_ff;
      done_in       = 1'b0;
      forced_in     = 1'b0;
      if (start) begin
         if (phase_ff == uer_pkg::PH_IDLE) begin
            phase_in      = uer_pkg::PH_TRIG;
            tick_count_in = '0;
         end
      end else begin
         unique case (phase_ff)
            uer_pkg::PH_IDLE: ;
            uer_pkg::PH_TRIG: begin
               tick_count_in = count_inc;
               if (count_inc_ext >= CMP_W'(trig_width_ff) || count_sat) begin
                  phase_in      = uer_pkg::PH_WAIT;
                  tick_count_in = '0;
               end
            end
            uer_pkg::PH_WAIT: begin
               if (echo) begin
                  phase_in      = uer_pkg::PH_MEAS;
                  tick_count_in = '0;
               end else begin
                  tick_count_in = count_inc;
                  if (count_inc_ext >= CMP_W'(rise_timeout_ff) || count_sat) begin
                     phase_in      = uer_pkg::PH_IDLE;
                     tick_count_in = '0;
                     done_in       = 1'b1;
                     forced_in     = 1'b1;
                  end
               end
            end
            uer_pkg::PH_MEAS: begin
               if (echo) begin
                  tick_count_in = count_inc;
                  if (count_inc_ext >= CMP_W'(echo_timeout_ff) || count_sat) begin
                     forced_in = 1'b1;
                     done_in   = 1'b1;
                  end
               end else begin
                  done_in = 1'b1;
               end
               if (done_in) begin
                  phase_in      = uer_pkg::PH_IDLE;
                  tick_count_in = '0;
               end
            end
            default: ;
         endcase
      end
   end

   // Finished echo time and its early checks
   uer_pkg::finish_type fin_in;

   assign fin_in.high_ticks = count_ext[uer_pkg::TIME_W-1:0];
   assign fin_in.pre_ok     = !forced_in
                              && (count_ext >= CMP_W'(uer_pkg::MIN_ECHO_TICKS))
                              && (count_ext <  CMP_W'(echo_timeout_ff));

   // Stage one output register
   logic                s1_valid_ff;
   logic                s1_trig_ff;
   logic                s1_busy_ff;
   logic                s1_done_ff;
   uer_pkg::finish_type s1_fin_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_accept;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_trig_ff <= (phase_in == uer_pkg::PH_TRIG);
         s1_busy_ff <= (phase_in != uer_pkg::PH_IDLE);
         s1_done_ff <= done_in;
         s1_fin_ff  <= fin_in;
      end
   end

   // Stage two: distance and limits
   uer_pkg::range_type range;

   uer_range_check u_range_check (
      .fin        (s1_fin_ff),
      .min_dist   (min_dist_ff),
      .max_dist   (max_dist_ff),
      .alarm_dist (alarm_dist_ff),
      .result     (range)
   );

   // Result register; the last-measurement fields hold until the next finish
   logic                       rsp_valid_ff;
   logic                       rsp_trig_ff;
   logic                       rsp_busy_ff;
   logic                       rsp_done_ff;
   logic                       last_valid_ff;
   logic [uer_pkg::DIST_W-1:0] last_dist_ff;
   logic                       last_too_close_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff      <= 1'b0;
         last_valid_ff     <= 1'b0;
         last_dist_ff      <= uer_pkg::INVALID_CM;
         last_too_close_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= s1_valid_ff;
         if (s1_valid_ff && s1_done_ff) begin
            last_valid_ff     <= range.valid;
            last_dist_ff      <= range.distance;
            last_too_close_ff <= range.too_close;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance && s1_valid_ff) begin
         rsp_trig_ff <= s1_trig_ff;
         rsp_busy_ff <= s1_busy_ff;
         rsp_done_ff <= s1_done_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {last_too_close_ff, last_dist_ff, last_valid_ff,
                        rsp_done_ff, rsp_busy_ff, rsp_trig_ff};

`ifndef NO_ASSERTIONS
   // A finishing request never leaves the block busy
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_done_ff) |-> !s1_busy_ff)
      else $error("finished measurement still marked busy");

   // Trigger only within a measurement
   a_trig_busy: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s1_trig_ff |-> s1_busy_ff)
      else $error("trigger high while not busy");

   // Idle phase keeps a cleared counter
   a_idle_count: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == uer_pkg::PH_IDLE) |-> (tick_count_ff == '0))
      else $error("tick counter not cleared in idle");

   // Invalid results carry the invalid distance and no alarm
   a_invalid_dist: assert property (@(posedge clock) disable iff (reset)
      !last_valid_ff |-> (last_dist_ff == uer_pkg::INVALID_CM && !last_too_close_ff))
      else $error("invalid result with distance or alarm set");

   // Last-measurement fields only change on a finishing request
   a_last_hold: assert property (@(posedge clock) disable iff (reset)
      !(advance && s1_valid_ff && s1_done_ff) |=> $stable(last_dist_ff))
      else $error("last distance changed without a finish");
`endif

endmodule

// ===== tb/sv/uer_checker.sv =====
// Response checker for the ultrasonic echo ranger: shadow registers, phase predictor, compare.
module uer_checker #(
   parameter int COUNT_WIDTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,   // [0] echo_level, [7:1] zero
   input  logic        req_tuser,   // [0] req_type (1 = start, 0 = tick)
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [15:0] rsp_tdata,   // [0] trig_level, [1] busy_res, [2] done_res,
                                    // [3] valid_res, [14:4] distance_cm, [15] too_close
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   input  logic        csr_pready,
   output int          fail_count,
   output int          pending,
   output logic        pred_busy
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned COUNT_MAX    = (1 << COUNT_WIDTH) - 1;
   localparam int unsigned TICKS_PER_CM = 58;
   localparam int          PRINT_CAP    = 100;

   // one response word, laid out as rsp_tdata from the top bit down
   typedef struct packed {
      logic                       too_close;
      logic [uer_pkg::DIST_W-1:0] distance;
      logic                       valid;
      logic                       done;
      logic                       busy;
      logic                       trig;
   } reading_type;

   reading_type expected_readings[$];

   // shadow copy of the limit registers
   logic [uer_pkg::TRIG_W-1:0] trig_width;
   logic [uer_pkg::TIME_W-1:0] rise_timeout;
   logic [uer_pkg::TIME_W-1:0] echo_timeout;
   logic [uer_pkg::DIST_W-1:0] min_cm;
   logic [uer_pkg::DIST_W-1:0] max_cm;
   logic [uer_pkg::DIST_W-1:0] alarm_cm;

   // predicted sequencer state
   uer_pkg::phase_type         phase;
   int unsigned                ticks;
   logic [uer_pkg::DIST_W-1:0] last_cm;
   logic                       last_valid;
   logic                       last_close;

   task automatic report_mismatch(input string what);
      if (fail_count < PRINT_CAP)
         $display("%0t ns  checker: %s", $time, what);
      fail_count++;
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
   endtask

   // counter saturates rather than wrapping
   function automatic void count_tick();
      if (ticks < COUNT_MAX)
         ticks++;
   endfunction

   // close a measurement: range check and store of the last result
   function automatic void settle_measurement(input int unsigned echo_ticks,
                                              input logic forced_bad);
      int unsigned cm;
      logic        ok;
      cm = echo_ticks / TICKS_PER_CM;
      ok = !forced_bad && echo_ticks >= uer_pkg::MIN_ECHO_TICKS &&
           echo_ticks < echo_timeout && cm <= max_cm && cm >= min_cm;
      if (ok) begin
         last_cm    = cm[uer_pkg::DIST_W-1:0];
         last_valid = 1'b1;
         last_close = (cm <= alarm_cm);
      end else begin
         last_cm    = uer_pkg::INVALID_CM;
         last_valid = 1'b0;
         last_close = 1'b0;
      end
      phase = uer_pkg::PH_IDLE;
      ticks = 0;
   endfunction

   // advance the phase sequencer by one request and form its response
   function automatic reading_type advance_ranger(input logic start, input logic echo);
      reading_type r;
      logic        done;
      done = 1'b0;
      if (start) begin
         // a start while busy is dropped
         if (phase == uer_pkg::PH_IDLE) begin
            phase = uer_pkg::PH_TRIG;
            ticks = 0;
         end
      end else begin
         case (phase)
            uer_pkg::PH_TRIG: begin
               count_tick();
               if (ticks >= trig_width || ticks >= COUNT_MAX) begin
                  phase = uer_pkg::PH_WAIT;
                  ticks = 0;
               end
            end
            uer_pkg::PH_WAIT: begin
               if (echo) begin
                  // rising tick itself is not counted
                  phase = uer_pkg::PH_MEAS;
                  ticks = 0;
               end else begin
                  count_tick();
                  if (ticks >= rise_timeout || ticks >= COUNT_MAX) begin
                     settle_measurement(0, 1'b1);
                     done = 1'b1;
                  end
               end
            end
            uer_pkg::PH_MEAS: begin
               if (echo) begin
                  count_tick();
                  if (ticks >= echo_timeout || ticks >= COUNT_MAX) begin
                     settle_measurement(ticks, 1'b1);
                     done = 1'b1;
                  end
               end else begin
                  settle_measurement(ticks, 1'b0);
                  done = 1'b1;
               end
            end
            default: ;
         endcase
      end
      r.trig      = (phase == uer_pkg::PH_TRIG);
      r.busy      = (phase != uer_pkg::PH_IDLE);
      r.done      = done;
      r.valid     = last_valid;
      r.distance  = last_cm;
      r.too_close = last_close;
      return r;
   endfunction

   // watch all three ports on each rising edge
   always @(posedge clock) begin : watch
      reading_type got;
      reading_type want;
      if (reset) begin
         trig_width   = uer_pkg::TRIG_WIDTH_RST;
         rise_timeout = uer_pkg::RISE_TIMEOUT_RST;
         echo_timeout = uer_pkg::ECHO_TIMEOUT_RST;
         min_cm       = uer_pkg::MIN_DIST_RST;
         max_cm       = uer_pkg::MAX_DIST_RST;
         alarm_cm     = uer_pkg::ALARM_DIST_RST;
         phase        = uer_pkg::PH_IDLE;
         ticks        = 0;
         last_cm      = uer_pkg::INVALID_CM;
         last_valid   = 1'b0;
         last_close   = 1'b0;
         fail_count   = 0;
         expected_readings.delete();
      end else begin
         // register writes, masked to each register's width
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[4:2])
               uer_pkg::REG_TRIG_WIDTH:   trig_width   = csr_pwdata[uer_pkg::TRIG_W-1:0];
               uer_pkg::REG_RISE_TIMEOUT: rise_timeout = csr_pwdata[uer_pkg::TIME_W-1:0];
               uer_pkg::REG_ECHO_TIMEOUT: echo_timeout = csr_pwdata[uer_pkg::TIME_W-1:0];
               uer_pkg::REG_MIN_DIST:     min_cm       = csr_pwdata[uer_pkg::DIST_W-1:0];
               uer_pkg::REG_MAX_DIST:     max_cm       = csr_pwdata[uer_pkg::DIST_W-1:0];
               uer_pkg::REG_ALARM_DIST:   alarm_cm     = csr_pwdata[uer_pkg::DIST_W-1:0];
               default: ;
            endcase
         end
         // responses against the oldest prediction
         if (rsp_tvalid && rsp_tready) begin
            got = reading_type'(rsp_tdata);
            if (expected_readings.size() == 0) begin
               report_mismatch($sformatf("response %h with nothing expected", rsp_tdata));
            end else begin
               want = expected_readings.pop_front();
               check_field("trig_level", 32'(got.trig), 32'(want.trig));
               check_field("busy_res", 32'(got.busy), 32'(want.busy));
               check_field("done_res", 32'(got.done), 32'(want.done));
               check_field("valid_res", 32'(got.valid), 32'(want.valid));
               check_field("distance_cm", 32'(got.distance), 32'(want.distance));
               check_field("too_close", 32'(got.too_close), 32'(want.too_close));
            end
         end
         // every request yields exactly one response
         if (req_tvalid && req_tready)
            expected_readings.push_back(advance_ranger(req_tuser, req_tdata[0]));
      end
      pending   = expected_readings.size();
      pred_busy = (phase != uer_pkg::PH_IDLE);
   end

endmodule

// ===== tb/sv/tb_ultrasonic_echo_ranger.sv =====
// Testbench top for the ultrasonic echo ranger: clock, reset, stimulus and verdict.
module tb_ultrasonic_echo_ranger;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int         COUNT_WIDTH = 16;
   localparam int         STALL_LIMIT = 5000;
   localparam int         HOLD_CYCLES = 300;
   localparam logic [2:0] REG_UNUSED  = 3'd6;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata   = '0;   // [0] echo_level, [7:1] zero
   logic        req_tuser   = 1'b0; // [0] req_type (1 = start, 0 = tick)
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [15:0] rsp_tdata;          // [0] trig_level, [1] busy_res, [2] done_res,
                                    // [3] valid_res, [14:4] distance_cm, [15] too_close
   logic        csr_psel    = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite  = 1'b0;
   logic [4:0]  csr_paddr   = '0;
   logic [31:0] csr_pwdata  = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   int   fail_count;
   int   pending;
   logic pred_busy;

   // stimulus-side copy of the limits, for shaping sequences
   int cfg_trig, cfg_rise;
   int idle_odds;
   bit quiet;
   bit hold_requested;
   int stall_cycles;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   ultrasonic_echo_ranger #(.COUNT_WIDTH(COUNT_WIDTH)) u_dut (
      .clock, .reset,
      .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata,
      .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr, .csr_pwdata,
      .csr_prdata, .csr_pready
   );

   uer_checker #(.COUNT_WIDTH(COUNT_WIDTH)) u_checker (
      .clock, .reset,
      .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata,
      .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr, .csr_pwdata, .csr_pready,
      .fail_count, .pending, .pred_busy
   );

   // watchdog: too long without any accepted transfer
   always @(posedge clock) begin
      if (reset)
         stall_cycles = 0;
      else if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
               (csr_psel && csr_penable && csr_pready))
         stall_cycles = 0;
      else
         stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("FAIL ultrasonic_echo_ranger");
         $finish;
      end
   end

   // result side: random back-pressure bursts and one long hold-off
   initial begin : receiver
      bit hold_done;
      hold_done = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_requested && !hold_done) begin
            hold_done = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_tready <= 1'b1;
         end else if (!quiet && idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clock);
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b1;
         end
         @(posedge clock);
      end
   end

   // offer one request, with an optional gap first; returns at the accepting edge
   task automatic offer_request(input logic start, input logic echo);
      if (!quiet && idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= start;
      req_tdata  <= {7'b0, echo};
      do @(posedge clock); while (!req_tready);
   endtask

   // stop offering and wait for every response to come back
   task automatic await_readings();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   // tick with the echo low until no measurement is running
   task automatic settle_idle();
      await_readings();
      while (pred_busy) begin
         repeat (32) offer_request(1'b0, 1'b0);
         await_readings();
      end
   endtask

   task automatic csr_write(input logic [2:0] index, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic apply_limits(input int trig, input int rise, input int echo_to,
                               input int lo_cm, input int hi_cm, input int alarm);
      settle_idle();
      csr_write(uer_pkg::REG_TRIG_WIDTH, trig);
      csr_write(uer_pkg::REG_RISE_TIMEOUT, rise);
      csr_write(uer_pkg::REG_ECHO_TIMEOUT, echo_to);
      csr_write(uer_pkg::REG_MIN_DIST, lo_cm);
      csr_write(uer_pkg::REG_MAX_DIST, hi_cm);
      csr_write(uer_pkg::REG_ALARM_DIST, alarm);
      cfg_trig = trig;
      cfg_rise = rise;
   endtask

   // stray start now and then while busy
   task automatic maybe_noise(input bit noisy);
      if (noisy && $urandom_range(0, 31) == 0)
         offer_request(1'b1, 1'($urandom_range(0, 1)));
   endtask

   // one well-formed measurement: start, trigger ticks, low wait, high echo, fall
   task automatic run_echo(input int rise_delay, input int echo_len, input bit noisy);
      offer_request(1'b1, 1'($urandom_range(0, 1)));
      if (noisy)
         offer_request(1'b1, 1'($urandom_range(0, 1)));
      repeat (cfg_trig) begin
         offer_request(1'b0, 1'($urandom_range(0, 1)));
         maybe_noise(noisy);
      end
      repeat (rise_delay) begin
         offer_request(1'b0, 1'b0);
         maybe_noise(noisy);
      end
      offer_request(1'b0, 1'b1);
      repeat (echo_len) begin
         offer_request(1'b0, 1'b1);
         maybe_noise(noisy);
      end
      offer_request(1'b0, 1'b0);
   endtask

   // short trigger and rise window, random limits
   task automatic shuffle_limits();
      apply_limits(int'($urandom_range(10, 12)), int'($urandom_range(1, 8)),
                   int'($urandom_range(151, 900)), int'($urandom_range(0, 5)),
                   int'($urandom_range(2, 15)), int'($urandom_range(0, 12)));
      case ($urandom_range(0, 2))
         0: idle_odds = 0;
         1: idle_odds = 3;
         default: idle_odds = 8;
      endcase
   endtask

   // short echoes, rise delays up to and including the rise timeout
   task automatic random_batch(input int count);
      repeat (count) begin
         repeat ($urandom_range(0, 3)) offer_request(1'b0, 1'($urandom_range(0, 1)));
         run_echo(int'($urandom_range(0, cfg_rise)), int'($urandom_range(0, 30)),
                  1'($urandom_range(0, 1)));
      end
   endtask

   initial begin : stimulus
      quiet          = 1'b0;
      hold_requested = 1'b0;
      idle_odds      = 4;
      cfg_trig       = int'(uer_pkg::TRIG_WIDTH_RST);
      cfg_rise       = int'(uer_pkg::RISE_TIMEOUT_RST);
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // reset limits: ticks while idle, then a short echo with stray starts
      offer_request(1'b0, 1'b1);
      offer_request(1'b0, 1'b0);
      run_echo(2, 10, 1'b1);

      // shortest trigger, quick rise timeout, echo timeout right at 151
      apply_limits(10, 3, 151, 0, 2, 2);
      // masked upper bits and a write to an unused slot
      csr_write(uer_pkg::REG_TRIG_WIDTH, 32'hABCD_FF00 | 32'(cfg_trig));
      csr_write(REG_UNUSED, 32'h0000_0155);
      run_echo(3, 0, 1'b0);
      run_echo(0, 0, 1'b0);

      // shortest valid echo under the long result hold-off, then the echo timeout
      hold_requested = 1'b1;
      run_echo(1, 150, 1'b0);
      run_echo(0, 151, 1'b0);

      // random limits with idling
      shuffle_limits();
      random_batch(1);

      // closing stretch without idling
      shuffle_limits();
      quiet = 1'b1;
      random_batch(1);

      await_readings();
      repeat (8) @(posedge clock);
      if (fail_count == 0)
         $display("PASS ultrasonic_echo_ranger");
      else
         $display("FAIL ultrasonic_echo_ranger");
      $finish;
   end

endmodule
